// ===== rtl/utf8_preview_space_collapser_top_defines.svh =====
// assertion macros for the utf8 preview space collapser
// used by utf8_preview_space_collapser_top; needs aclk and aresetn in scope
`ifndef UTF8_PREVIEW_SPACE_COLLAPSER_TOP_DEFINES_SVH
`define UTF8_PREVIEW_SPACE_COLLAPSER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U8PSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define U8PSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/u8psc_pkg.sv =====
// shared types and helper functions for the utf8 preview space collapser
// no dependencies; imported by u8psc_step and the top level
`default_nettype none

package u8psc_pkg;

    localparam int unsigned PartialW = 31;
    localparam int unsigned CodeW    = 21;
    localparam int unsigned CountW   = 16;

    localparam logic [CountW-1:0] CountMax   = 16'hFFFF;
    localparam logic [CodeW-1:0]  SpaceCode  = 21'h000020;
    localparam logic [PartialW-1:0] CodeLimit = 31'h0011_0000;
    localparam logic [19:0] SurrogateTag = 20'h0001B; // 0xD800 >> 11

    typedef struct packed {
        logic [PartialW-1:0] partial;
        logic [2:0]          bytes_left;
        logic [2:0]          seq_len;
        logic                prev_space;
        logic [CountW-1:0]   count;
        logic                stopped;
    } state_t;

    typedef struct packed {
        logic             emit;
        logic [CodeW-1:0] code_point;
        logic             stop;
    } result_t;

    function automatic logic [PartialW-1:0] min_for_length(input logic [2:0] len);
        logic [PartialW-1:0] m;
        case (len)
            3'd2:    m = 31'h0000_0080;
            3'd3:    m = 31'h0000_0800;
            3'd4:    m = 31'h0001_0000;
            3'd5:    m = 31'h0020_0000;
            default: m = 31'h0400_0000;
        endcase
        return m;
    endfunction

    function automatic logic acceptable(input logic [PartialW-1:0] v, input logic [2:0] len);
        return (v >= min_for_length(len)) && (v != '0) && (v < CodeLimit)
            && (v[PartialW-1:11] != SurrogateTag);
    endfunction

    function automatic logic is_white(input logic [CodeW-1:0] c);
        return (c == 21'h09) || (c == 21'h0A) || (c == 21'h0C) || (c == 21'h0D)
            || (c == 21'h20) || (c == 21'hA0) || (c == 21'h1680)
            || ((c >= 21'h2000) && (c <= 21'h200A))
            || (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F)
            || (c == 21'h205F) || (c == 21'h3000);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/u8psc_step.sv =====
// one-byte update of the utf8 decoder and whitespace collapser
// combinational; depends on u8psc_pkg
`default_nettype none

module u8psc_step (
    input  u8psc_pkg::state_t              cur,
    input  logic [7:0]                     text_byte,
    input  logic                           chunk_end,
    input  logic                           restart,
    input  logic [u8psc_pkg::CountW-1:0]   char_limit,
    output u8psc_pkg::state_t              nxt,
    output u8psc_pkg::result_t             res
);
    import u8psc_pkg::*;

    state_t            s;
    logic              have;
    logic [CodeW-1:0]  cp;
    logic [2:0]        left_dec;
    logic [PartialW-1:0] shifted;
    logic              white;
    logic [CountW-1:0] count_next;

    always_comb begin
        s          = restart ? '0 : cur;
        nxt        = s;
        res        = '0;
        have       = 1'b0;
        cp         = '0;
        left_dec   = s.bytes_left - 3'd1;
        shifted    = {s.partial[PartialW-7:0], text_byte[5:0]};
        white      = 1'b0;
        count_next = s.count;

        if (!s.stopped) begin
            if (text_byte[7:6] == 2'b10) begin
                // continuation byte; ignored unless a sequence is open
                if (s.bytes_left != 3'd0) begin
                    nxt.partial    = shifted;
                    nxt.bytes_left = left_dec;
                    if (left_dec == 3'd0 && acceptable(shifted, s.seq_len)) begin
                        have = 1'b1;
                        cp   = shifted[CodeW-1:0];
                    end
                end
            end else begin
                nxt.bytes_left = 3'd0;
                if (!text_byte[7]) begin
                    have = (text_byte != 8'h00);
                    cp   = {{(CodeW-8){1'b0}}, text_byte};
                end else if (text_byte < 8'hE0) begin
                    nxt.seq_len    = 3'd2;
                    nxt.partial    = {{(PartialW-5){1'b0}}, text_byte[4:0]};
                    nxt.bytes_left = 3'd1;
                end else if (text_byte < 8'hF0) begin
                    nxt.seq_len    = 3'd3;
                    nxt.partial    = {{(PartialW-4){1'b0}}, text_byte[3:0]};
                    nxt.bytes_left = 3'd2;
                end else if (text_byte < 8'hF8) begin
                    nxt.seq_len    = 3'd4;
                    nxt.partial    = {{(PartialW-3){1'b0}}, text_byte[2:0]};
                    nxt.bytes_left = 3'd3;
                end else if (text_byte < 8'hFC) begin
                    nxt.seq_len    = 3'd5;
                    nxt.partial    = {{(PartialW-2){1'b0}}, text_byte[1:0]};
                    nxt.bytes_left = 3'd4;
                end else if (text_byte < 8'hFE) begin
                    nxt.seq_len    = 3'd6;
                    nxt.partial    = {{(PartialW-1){1'b0}}, text_byte[0]};
                    nxt.bytes_left = 3'd5;
                end
            end

            // an open sequence does not survive the chunk boundary
            if (chunk_end) begin
                nxt.bytes_left = 3'd0;
            end

            if (have) begin
                white = is_white(cp);
                if (white) begin
                    res.emit       = !s.prev_space && (s.count != '0);
                    res.code_point = SpaceCode;
                end else begin
                    res.emit       = 1'b1;
                    res.code_point = cp;
                end
                nxt.prev_space = white;
                if (res.emit && s.count != CountMax) begin
                    count_next = s.count + CountW'(1);
                end
                nxt.count = count_next;
                if (char_limit != '0 && count_next >= char_limit) begin
                    nxt.stopped = 1'b1;
                end
                res.stop = nxt.stopped;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/utf8_preview_space_collapser_top.sv =====
// top level of the utf8 preview space collapser: input register, step logic, output register
// depends on u8psc_pkg, u8psc_step and the assertion macro header
//
//  channel   dir  tdata                       tuser      tlast
//  s_        in   [7:0] text_byte             restart    chunk_end
//  m_        out  [20:0] code_point, pad 0    -          stop
//  cfg_      in   [15:0] char_limit (write-only, cfg_wr_en strobe)
//
// one byte per cycle sustained while the output register is free (empty or m_tready high);
// a byte passes through the input register, and a character it yields through the output register
// the decoder state update is combinational, so bytes follow back to back
// output stalls backpressure through the input register; s_tready drops only when
// both registers hold data and m_tready is low
// aresetn (synchronous, active low) clears decoder state, char_limit and valid flags
`default_nettype none

`include "utf8_preview_space_collapser_top_defines.svh"

module utf8_preview_space_collapser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,   // char_limit
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] text_byte
    input  logic        s_tlast,       // chunk_end
    input  logic        s_tuser,       // restart
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,       // [20:0] code_point, [23:21] zero
    output logic        m_tlast        // stop
);
    import u8psc_pkg::*;

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              in_last_reg;
    logic              in_restart_reg;
    state_t            st_reg;
    state_t            st_next;
    result_t           res;
    logic [CountW-1:0] char_limit_reg;
    logic              m_valid_reg;
    logic [CodeW-1:0]  m_code_reg;
    logic              m_stop_reg;
    logic              out_free;
    logic              proc_fire;
    logic              s_fire;

    assign out_free  = !m_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign s_fire    = s_tvalid && s_tready;

    u8psc_step u_step (
        .cur        (st_reg),
        .text_byte  (in_byte_reg),
        .chunk_end  (in_last_reg),
        .restart    (in_restart_reg),
        .char_limit (char_limit_reg),
        .nxt        (st_next),
        .res        (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            st_reg         <= '0;
            char_limit_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                char_limit_reg <= cfg_wr_data;
            end
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc_fire) begin
                st_reg <= st_next;
            end
            if (out_free) begin
                m_valid_reg <= proc_fire && res.emit;
            end
        end
    end

    // payload registers, loaded on transaction only
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg    <= s_tdata;
            in_last_reg    <= s_tlast;
            in_restart_reg <= s_tuser;
        end
        if (proc_fire && res.emit) begin
            m_code_reg <= res.code_point;
            m_stop_reg <= res.stop;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(24-CodeW){1'b0}}, m_code_reg};
    assign m_tlast  = m_stop_reg;

    `U8PSC_ASSERT_NEXT(a_emit_loads_output, proc_fire && res.emit, m_valid_reg,
        "emitted character not loaded into output register")
    `U8PSC_ASSERT_NOW(a_stopped_silent, proc_fire && st_reg.stopped && !in_restart_reg,
        !res.emit, "character emitted while stopped")
    `U8PSC_ASSERT_NOW(a_code_legal, m_valid_reg,
        (m_code_reg != '0) && (m_code_reg < 21'h110000) && (m_code_reg[20:11] != 10'h01B),
        "illegal code point on output")

endmodule

`default_nettype wire
